### hw/rtl/lmds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmds_pkg
// Shared widths, reset values, register codes and the structs passed between
// the blocks of the limb to digit splitter.
// ----------------------------------------------------------------------------
package lmds_pkg;

  // field widths
  localparam int LIMB_W     = 64;
  localparam int DIGIT_W    = 63;
  localparam int IDX_W      = 12;
  localparam int WIDTH_W    = 6;
  localparam int CNT_W      = 6;
  localparam int AVAIL_W    = 7;
  localparam int M_TDATA_W  = 80;
  localparam int TDATA_PAD  = M_TDATA_W - DIGIT_W - IDX_W;

  // digit position table
  localparam int MAX_DIGITS = 4096;
  localparam int POS_W      = $clog2(MAX_DIGITS + 1);

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME      = 2'd1;

  // reset values and limits
  localparam logic [WIDTH_W-1:0] DIGIT_BITS_RESET = 6'd32;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH        = 6'd2;
  localparam logic [DIGIT_W-1:0] PRIME_RESET      = 63'd2305843009213693951;
  localparam logic [AVAIL_W-1:0] LIMB_BITS        = 7'd64;

  // request to the shared shift and merge unit
  typedef struct packed {
    logic [LIMB_W-1:0]  w;
    logic [DIGIT_W-1:0] acc;
    logic [CNT_W-1:0]   cnt;
    logic [WIDTH_W-1:0] m;
  } unit_req_t;

  // answer of the shared shift and merge unit
  typedef struct packed {
    logic [LIMB_W-1:0]  w_rest;
    logic               more_bits;
    logic [DIGIT_W-1:0] digit;
    logic [DIGIT_W-1:0] tail;
    logic [WIDTH_W-1:0] need;
  } unit_rsp_t;

  // one raw digit with its position
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [IDX_W-1:0]   index;
    logic               overflow;
    logic               neg;
  } digit_rec_t;

  // digit handed to the output register
  typedef struct packed {
    digit_rec_t rec;
    logic       run_end;
    logic       number_end;
  } out_push_t;

endpackage
`default_nettype wire

### hw/rtl/lmds_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmds_cfg
// Configuration registers: digit width and negation prime. Reports a width
// write so the splitter can drop any number in progress.
// ----------------------------------------------------------------------------
module lmds_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lmds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lmds_pkg::DIGIT_W-1:0]     cfg_data,
  output logic [lmds_pkg::WIDTH_W-1:0]          digit_width,
  output logic [lmds_pkg::DIGIT_W-1:0]          prime,
  output logic                                  width_write
);
  import lmds_pkg::*;

  logic [WIDTH_W-1:0] digit_bits;
  logic               cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_bits <= DIGIT_BITS_RESET;
      prime      <= PRIME_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIGIT_BITS: digit_bits <= cfg_data[WIDTH_W-1:0];
        REG_PRIME:      prime      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_write = cfg_write && (cfg_index == REG_DIGIT_BITS);

  // widths below two act as two
  assign digit_width = (digit_bits < MIN_WIDTH) ? MIN_WIDTH : digit_bits;

endmodule
`default_nettype wire

### hw/rtl/lmds_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmds_unit
// Shared shift and merge unit: joins carried bits with the low bits of the
// remaining limb and shifts the consumed bits away, one digit per use.
// ----------------------------------------------------------------------------
module lmds_unit (
  input  lmds_pkg::unit_req_t req,
  output lmds_pkg::unit_rsp_t rsp
);
  import lmds_pkg::*;

  logic [WIDTH_W-1:0] need;
  logic [WIDTH_W-1:0] top_pos;
  logic [LIMB_W-1:0]  w_shl;
  logic [DIGIT_W-1:0] joined;
  logic [DIGIT_W-1:0] dmask;

  always_comb begin
    // bits still missing from the current digit
    need    = req.m - req.cnt;
    top_pos = need - 6'd1;
    // limb bits placed above the carried bits
    w_shl   = req.w << req.cnt;
    joined  = req.acc | w_shl[DIGIT_W-1:0];
    dmask   = (63'd1 << req.m) - 63'd1;

    rsp.need      = need;
    rsp.w_rest    = req.w >> need;
    // remaining value has at least need significant bits
    rsp.more_bits = (rsp.w_rest != '0) || req.w[top_pos];
    rsp.digit     = joined & dmask;
    rsp.tail      = joined;
  end

endmodule
`default_nettype wire

### hw/rtl/lmds_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmds_out
// Output register of the digit stream; applies the negation against the
// prime as a digit is loaded.
// ----------------------------------------------------------------------------
module lmds_out (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  lmds_pkg::out_push_t                  push_data,
  input  wire logic [lmds_pkg::DIGIT_W-1:0]    prime,
  output logic                                 out_free,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [lmds_pkg::M_TDATA_W-1:0]       m_tdata,  // digit, digit_index, zero pad
  output logic                                 m_tlast,  // run_end
  output logic [1:0]                           m_tuser   // number_end, index_overflow
);
  import lmds_pkg::*;

  logic [DIGIT_W-1:0] digit_val;

  assign out_free = !m_tvalid || m_tready;

  // nonzero digits of a negative number become prime minus digit
  always_comb begin
    if (push_data.rec.neg && (push_data.rec.digit != '0)) begin
      digit_val = prime - push_data.rec.digit;
    end else begin
      digit_val = push_data.rec.digit;
    end
  end

  // word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // word payload
  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= {{TDATA_PAD{1'b0}}, push_data.rec.index, digit_val};
      m_tlast <= push_data.run_end;
      m_tuser <= {push_data.rec.overflow, push_data.number_end};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/limb_to_modular_digit_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// limb_to_modular_digit_split
// Splits sign-magnitude big integers, given as 64-bit limbs least
// significant first, into M-bit digits, negated against a prime for
// negative numbers.
// ----------------------------------------------------------------------------
// A limb is taken only while the splitter is idle. One shared shift and merge
// unit produces one digit per cycle while the output register is free; a word
// held by the consumer stalls it. Each limb passes through the run and done
// states before the splitter is idle again. The last digit of a limb carries
// tlast, the last digit of a number sets tuser[0], and a digit past the
// position table sets tuser[1] with index zero. Writing the digit width drops
// any number in progress.
module limb_to_modular_digit_split (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // limb input
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [lmds_pkg::LIMB_W-1:0]     s_tdata,   // limb
  input  wire logic                            s_tuser,   // negative
  input  wire logic                            s_tlast,   // final_limb
  // digit output
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [lmds_pkg::M_TDATA_W-1:0]       m_tdata,   // digit, digit_index, zero pad
  output logic                                 m_tlast,   // run_end
  output logic [1:0]                           m_tuser,   // number_end, index_overflow
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lmds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lmds_pkg::DIGIT_W-1:0]    cfg_data
);
  import lmds_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state;
  logic [LIMB_W-1:0]  w;
  logic [DIGIT_W-1:0] acc;
  logic [CNT_W-1:0]   cnt;
  logic [AVAIL_W-1:0] avail;
  logic               neg;
  logic               fin;
  logic [POS_W-1:0]   pos;
  digit_rec_t         pend;
  logic               pend_valid;

  logic [WIDTH_W-1:0] m_width;
  logic [DIGIT_W-1:0] prime;
  logic               width_write;
  logic               out_free;
  logic               accept;
  logic               step;
  logic               cont;
  logic               produce;
  logic               pos_ovf;
  logic               push;
  unit_req_t          req;
  unit_rsp_t          rsp;
  digit_rec_t         new_rec;
  out_push_t          push_data;

  lmds_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .digit_width (m_width),
    .prime       (prime),
    .width_write (width_write)
  );

  lmds_unit u_unit (
    .req (req),
    .rsp (rsp)
  );

  lmds_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .prime     (prime),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign step     = out_free;

  // shared unit inputs
  always_comb begin
    req.w   = w;
    req.acc = acc;
    req.cnt = cnt;
    req.m   = m_width;
  end

  // digit decision for this cycle
  always_comb begin
    if (fin) begin
      cont = rsp.more_bits;
    end else begin
      cont = ({1'b0, rsp.need} <= avail);
    end
    produce = (state == ST_RUN) && step && (cont || (fin && (rsp.tail != '0)));
    pos_ovf = (pos >= POS_W'(MAX_DIGITS));

    new_rec.digit    = cont ? rsp.digit : rsp.tail;
    new_rec.neg      = neg;
    new_rec.overflow = pos_ovf;
    new_rec.index    = pos_ovf ? '0 : IDX_W'(pos);
  end

  // pending digit goes out once the next decision is known
  always_comb begin
    push_data.rec        = pend;
    push_data.run_end    = (state == ST_DONE);
    push_data.number_end = (state == ST_DONE) && fin;
    push = pend_valid && step && (produce || (state == ST_DONE));
  end

  // sequencer and carried state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      acc        <= '0;
      cnt        <= '0;
      pos        <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            w     <= s_tdata;
            avail <= LIMB_BITS;
            neg   <= s_tuser;
            fin   <= s_tlast;
            if (cnt >= m_width) begin
              acc <= '0;
              cnt <= '0;
            end
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step) begin
            if (produce) begin
              pend       <= new_rec;
              pend_valid <= 1'b1;
              if (!pos_ovf) begin
                pos <= pos + POS_W'(1);
              end
            end
            if (cont) begin
              w     <= rsp.w_rest;
              avail <= avail - {1'b0, rsp.need};
              acc   <= '0;
              cnt   <= '0;
            end else begin
              if (!fin) begin
                acc <= rsp.tail;
                cnt <= CNT_W'({1'b0, cnt} + avail);
              end
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (step) begin
            pend_valid <= 1'b0;
            if (fin) begin
              acc <= '0;
              cnt <= '0;
              pos <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // a new digit width abandons the number in progress
      if (width_write) begin
        acc <= '0;
        cnt <= '0;
        pos <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // no digit is left behind once a limb is finished
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending digit while idle");

  // position never passes the table size
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_DIGITS))
    else $error("digit position beyond table size");

  // carried bits always stay short of a full digit while working
  a_cnt_short: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (cnt < m_width))
    else $error("carried bit count reached digit width");

  // overflowed digits carry index zero
  a_ovf_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[DIGIT_W +: IDX_W] == '0))
    else $error("overflowed digit with nonzero index");
`endif

endmodule
`default_nettype wire
